FILE: hdl/pfd_pkg.sv
package pfd_pkg;

	// Default build values
	localparam int MAX_CHANNELS_DEF = 8;
	localparam int FRAC_BITS_DEF    = 30;

	// Register indexes on the configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_FORMAT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd1;

	// Sample format codes
	localparam logic [1:0] FMT_U8  = 2'd0;
	localparam logic [1:0] FMT_S16 = 2'd1;
	localparam logic [1:0] FMT_S32 = 2'd2;
	localparam logic [1:0] FMT_F32 = 2'd3;

	// Reset values of the registers
	localparam logic [1:0] FORMAT_RST = FMT_S16;
	localparam logic [3:0] COUNT_RST  = 4'd1;

	// Quotient bits produced per cycle by the channel-count divider
	localparam int DIV_BITS = 8;

	// Full-scale divisors 2^k - 1 of the integer formats
	localparam int K16 = 15;
	localparam int K32 = 31;

	// Controller to datapath
	typedef struct packed {
		logic cfg_write;
		logic take_byte;
		logic norm_load;
		logic fold_step;
		logic accum;
		logic div_load;
		logic div_step;
		logic emit;
		logic clear;
	} pfd_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic sample_last;
		logic frame_last;
		logic fold_done;
	} pfd_sts_t;

endpackage

FILE: hdl/pfd_ctrl.sv
module pfd_ctrl #(
	parameter int MAX_CHANNELS = pfd_pkg::MAX_CHANNELS_DEF,
	parameter int FRAC_BITS    = pfd_pkg::FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              chunk_end,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output pfd_pkg::pfd_cmd_t cmd,
	input  pfd_pkg::pfd_sts_t sts
);
	import pfd_pkg::*;

	localparam int SUM_W   = $clog2(MAX_CHANNELS) + FRAC_BITS + 2;
	localparam int DIV_CYC = (SUM_W + DIV_BITS - 1) / DIV_BITS;
	localparam int DCW     = $clog2(DIV_CYC);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_NLOAD = 3'd1;
	localparam logic [2:0] S_FOLD  = 3'd2;
	localparam logic [2:0] S_DLOAD = 3'd3;
	localparam logic [2:0] S_DIV   = 3'd4;
	localparam logic [2:0] S_EMIT  = 3'd5;

	logic [2:0]     state_q, state_d;
	logic [DCW-1:0] dcnt_q;
	logic           pend_q;
	logic           out_valid_q;
	logic           in_acc;
	logic           out_free;

	assign in_ready  = (state_q == S_IDLE) && !cfg_valid;
	assign cfg_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.cfg_write = cfg_valid;
				cmd.take_byte = in_acc;
				if (in_acc) begin
					if (sts.sample_last) begin
						state_d = S_NLOAD;
					end else begin
						cmd.clear = chunk_end;
					end
				end
			end
			S_NLOAD: begin
				cmd.norm_load = 1'b1;
				state_d       = S_FOLD;
			end
			S_FOLD: begin
				if (sts.fold_done) begin
					cmd.accum = 1'b1;
					if (sts.frame_last) begin
						state_d = S_DLOAD;
					end else begin
						cmd.clear = pend_q;
						state_d   = S_IDLE;
					end
				end else begin
					cmd.fold_step = 1'b1;
				end
			end
			S_DLOAD: begin
				cmd.div_load = 1'b1;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (dcnt_q == DCW'(DIV_CYC - 1)) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (out_free) begin
					cmd.emit  = 1'b1;
					cmd.clear = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State, divider step count, pending chunk mark, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			dcnt_q      <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.div_load) begin
				dcnt_q <= '0;
			end else if (cmd.div_step) begin
				dcnt_q <= dcnt_q + DCW'(1);
			end
			if (in_acc) begin
				pend_q <= chunk_end;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: hdl/pfd_dp.sv
module pfd_dp #(
	parameter int MAX_CHANNELS = pfd_pkg::MAX_CHANNELS_DEF,
	parameter int FRAC_BITS    = pfd_pkg::FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  pfd_pkg::pfd_cmd_t                cmd,
	output pfd_pkg::pfd_sts_t                sts,
	input  logic [pfd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pfd_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic [7:0]                       data_byte,
	output logic signed [31:0]               mono_sample
);
	import pfd_pkg::*;

	localparam int SUM_W   = $clog2(MAX_CHANNELS) + FRAC_BITS + 2;
	localparam int DIV_CYC = (SUM_W + DIV_BITS - 1) / DIV_BITS;
	localparam int PAD_W   = DIV_CYC * DIV_BITS;
	localparam int CW      = $clog2(MAX_CHANNELS + 1);
	localparam int NW      = FRAC_BITS + 32;
	localparam int QW      = FRAC_BITS + 2;
	localparam int NORMW   = FRAC_BITS + 2;
	localparam int MAGW    = FRAC_BITS + 1;

	localparam logic [QW-1:0]   ONE_Q   = QW'(1) << FRAC_BITS;
	localparam logic [MAGW-1:0] ONE_M   = MAGW'(1) << FRAC_BITS;
	localparam logic [NW-1:0]   D16     = (NW'(1) << K16) - NW'(1);
	localparam logic [NW-1:0]   D32     = (NW'(1) << K32) - NW'(1);
	localparam logic [NW-1:0]   LO16    = D16;
	localparam logic [NW-1:0]   LO32    = D32;

	// Configuration and frame state
	logic [1:0]              fmt_q;
	logic [3:0]              cnt_q;
	logic [1:0]              byte_pos_q;
	logic [CW-1:0]           ch_pos_q;
	logic signed [SUM_W-1:0] sum_q;

	// Payload registers
	logic [31:0]             asm_q;
	logic [NW-1:0]           r_q;
	logic [QW-1:0]           q_q;
	logic [PAD_W-1:0]        dn_q;
	logic [CW-1:0]           rem_q;
	logic                    neg_q;
	logic signed [31:0]      mono_q;

	logic                    clr;
	logic [4:0]              cnt5;
	logic [CW-1:0]           count;
	logic                    is16;

	assign clr  = cmd.clear || cmd.cfg_write;
	assign is16 = (fmt_q == FMT_S16);

	// Effective channel count: zero reads as one, large values saturate
	always_comb begin
		cnt5 = {1'b0, cnt_q};
		if (cnt5 == 5'd0) begin
			count = CW'(1);
		end else if (cnt5 > 5'(MAX_CHANNELS)) begin
			count = CW'(MAX_CHANNELS);
		end else begin
			count = CW'(cnt5);
		end
	end

	// Status toward the controller
	logic [NW-1:0] f_hi, f_lo, f_d;
	always_comb begin
		f_hi = is16 ? (r_q >> K16) : (r_q >> K32);
		f_lo = is16 ? (r_q & LO16) : (r_q & LO32);
		f_d  = is16 ? D16 : D32;
		sts.sample_last = (fmt_q == FMT_U8) || (is16 && byte_pos_q == 2'd1) ||
			(byte_pos_q == 2'd3);
		sts.frame_last  = ({1'b0, ch_pos_q} + (CW+1)'(1)) >= {1'b0, count};
		sts.fold_done   = (fmt_q == FMT_U8) || (fmt_q == FMT_F32) ||
			((f_hi == '0) && (r_q != f_d));
	end

	// Magnitude of a signed integer sample, plus half the divisor
	logic [32:0]   nl_mag;
	logic [NW-1:0] nl_n;
	always_comb begin
		if (is16) begin
			nl_mag = asm_q[15] ? 33'(17'h10000 - {1'b0, asm_q[15:0]}) : 33'(asm_q[15:0]);
		end else begin
			nl_mag = asm_q[31] ? (33'h1_0000_0000 - {1'b0, asm_q}) : {1'b0, asm_q};
		end
		nl_n = (NW'(nl_mag) << FRAC_BITS) + (f_d >> 1);
	end

	// Float to fixed
	logic [7:0]        f_ex, f_exe;
	logic [23:0]       f_man;
	logic signed [9:0] f_sh;
	logic [9:0]        f_rs;
	logic [24:0]       f_rnd;
	logic [MAGW-1:0]   f_mag;
	always_comb begin
		f_ex  = asm_q[30:23];
		f_exe = (f_ex == 8'd0) ? 8'd1 : f_ex;
		f_man = {(f_ex != 8'd0), asm_q[22:0]};
		f_sh  = $signed({2'b00, f_exe}) + 10'(FRAC_BITS - 150);
		f_rs  = 10'(-f_sh);
		f_rnd = {1'b0, f_man} + (25'd1 << (f_rs[4:0] - 5'd1));
		if (f_ex == 8'hFF) begin
			f_mag = '0;
		end else if (f_ex >= 8'd127) begin
			f_mag = ONE_M;
		end else if (!f_sh[9]) begin
			f_mag = MAGW'(f_man) << f_sh[2:0];
		end else if (f_rs >= 10'd25) begin
			f_mag = '0;
		end else begin
			f_mag = MAGW'(f_rnd >> f_rs[4:0]);
		end
	end

	// Normalized sample of the current channel
	logic signed [7:0]       u8d;
	logic [MAGW-1:0]         qc;
	logic signed [NORMW-1:0] nmag, norm;
	always_comb begin
		u8d  = $signed({~asm_q[7], asm_q[6:0]});
		qc   = (q_q > ONE_Q) ? ONE_M : q_q[MAGW-1:0];
		nmag = '0;
		norm = '0;
		case (fmt_q)
			FMT_U8: begin
				norm = NORMW'(u8d) <<< (FRAC_BITS - 7);
			end
			FMT_S16: begin
				nmag = NORMW'(qc);
				norm = asm_q[15] ? -nmag : nmag;
			end
			FMT_S32: begin
				nmag = NORMW'(qc);
				norm = asm_q[31] ? -nmag : nmag;
			end
			default: begin
				nmag = NORMW'(f_mag);
				norm = asm_q[31] ? -nmag : nmag;
			end
		endcase
	end

	// Frame sum magnitude; half of the count is added for rounding at divider load
	logic [SUM_W-1:0] s_abs;
	always_comb begin
		s_abs = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	end

	// Divider by the channel count, DIV_BITS restoring steps per cycle
	logic [PAD_W-1:0] d_dn;
	logic [CW-1:0]    d_rem;
	logic [CW:0]      d_tmp;
	always_comb begin
		d_dn  = dn_q;
		d_rem = rem_q;
		d_tmp = '0;
		for (int i = 0; i < DIV_BITS; i++) begin
			d_tmp = {d_rem, d_dn[PAD_W-1]};
			d_dn  = {d_dn[PAD_W-2:0], 1'b0};
			if (d_tmp >= {1'b0, count}) begin
				d_rem   = CW'(d_tmp - {1'b0, count});
				d_dn[0] = 1'b1;
			end else begin
				d_rem = d_tmp[CW-1:0];
			end
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q      <= FORMAT_RST;
			cnt_q      <= COUNT_RST;
			byte_pos_q <= '0;
			ch_pos_q   <= '0;
			sum_q      <= '0;
		end else begin
			if (cmd.cfg_write) begin
				unique case (cfg_index)
					REG_SAMPLE_FORMAT: fmt_q <= cfg_data[1:0];
					REG_CHANNEL_COUNT: cnt_q <= cfg_data[3:0];
					default: ;
				endcase
			end
			if (clr) begin
				byte_pos_q <= '0;
				ch_pos_q   <= '0;
				sum_q      <= '0;
			end else begin
				if (cmd.take_byte) begin
					byte_pos_q <= sts.sample_last ? 2'd0 : byte_pos_q + 2'd1;
				end
				if (cmd.accum) begin
					ch_pos_q <= ch_pos_q + CW'(1);
					sum_q    <= sum_q + SUM_W'(norm);
				end
			end
		end
	end

	// Sample assembly, fold unit, divider and output data
	always_ff @(posedge clk) begin
		if (cmd.take_byte) begin
			case (byte_pos_q)
				2'd0:    asm_q[7:0]   <= data_byte;
				2'd1:    asm_q[15:8]  <= data_byte;
				2'd2:    asm_q[23:16] <= data_byte;
				default: asm_q[31:24] <= data_byte;
			endcase
		end
		// N / (2^k - 1): fold high part onto low part until below the divisor
		if (cmd.norm_load) begin
			r_q <= nl_n;
			q_q <= '0;
		end else if (cmd.fold_step) begin
			if (f_hi != '0) begin
				r_q <= f_lo + f_hi;
				q_q <= q_q + QW'(f_hi);
			end else begin
				r_q <= '0;
				q_q <= q_q + QW'(1);
			end
		end
		if (cmd.div_load) begin
			dn_q  <= PAD_W'(s_abs + SUM_W'(count >> 1));
			rem_q <= '0;
			neg_q <= sum_q[SUM_W-1];
		end else if (cmd.div_step) begin
			dn_q  <= d_dn;
			rem_q <= d_rem;
		end
		if (cmd.emit) begin
			mono_q <= neg_q ? -$signed(32'(dn_q)) : $signed(32'(dn_q));
		end
	end

	assign mono_sample = mono_q;

endmodule

FILE: hdl/pcm_frame_downmix.sv
// Interleaved little-endian PCM bytes in, one mono sample per frame out.
// Input channel: in_valid/in_ready with data_byte and chunk_end, one byte an
// item. Output channel: out_valid/out_ready with mono_sample, signed Q2.30
// (FRAC_BITS fractional bits), the rounded average of the frame's channels.
// Configuration channel: cfg_valid/cfg_ready with cfg_index and cfg_data;
// index 0 is sample_format, index 1 is channel_count, other indexes are
// ignored. A write drops any partial sample and frame.
// Steps: a byte that finishes a sample goes to the normalize step and, for
// 16- and 32-bit samples, to the fold unit dividing by full scale. A byte
// that finishes a frame then goes to the channel-count divider; the frame
// sum is SUM_W = clog2(MAX_CHANNELS) + FRAC_BITS + 2 bits wide.
// Reset: format signed 16-bit, one channel, empty frame, no result held.
// The result sits in an output register; more bytes are taken while it
// waits. Input is held off while a sample or frame is worked on, while
// cfg_valid is high, and when the next frame is done while out_ready is still low.
module pcm_frame_downmix #(
	parameter int MAX_CHANNELS = pfd_pkg::MAX_CHANNELS_DEF,
	parameter int FRAC_BITS    = pfd_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [7:0]                     data_byte,
	input  logic                           chunk_end,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [31:0]             mono_sample,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pfd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pfd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import pfd_pkg::*;

	pfd_cmd_t cmd;
	pfd_sts_t sts;

	pfd_ctrl #(
		.MAX_CHANNELS(MAX_CHANNELS),
		.FRAC_BITS   (FRAC_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.chunk_end(chunk_end),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	pfd_dp #(
		.MAX_CHANNELS(MAX_CHANNELS),
		.FRAC_BITS   (FRAC_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.data_byte  (data_byte),
		.mono_sample(mono_sample)
	);

endmodule
